FILE: hdl/hash_ordered_sample_select_defines.svh
// assertion macros for the hash ordered sample select block
`ifndef HASH_ORDERED_SAMPLE_SELECT_DEFINES_SVH
`define HASH_ORDERED_SAMPLE_SELECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define HOSS_ASSERT_NOW(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define HOSS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define HOSS_ASSERT_NOW(lbl, clk, rst, expr, msg)
`define HOSS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

FILE: hdl/hoss_pkg.sv
// shared types, constants and hash step for the hash ordered sample select block
`timescale 1ns / 1ps
`default_nettype none
package hoss_pkg;
   localparam int DEFAULT_ENTRY_CAPACITY = 64;
   localparam int CFG_W = 7;
   localparam int KEY_W = 31;
   localparam int VALUE_W = 64;
   localparam int HASH_W = 64;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_EXACT_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
   localparam logic [HASH_W-1:0] HASH_BASIS = 64'd1469598103934665603;
   // prime is 2^40 + 0x1b3
   localparam logic [8:0] HASH_PRIME_LO = 9'h1b3;

   typedef struct packed {
      logic [VALUE_W-1:0] value_bits;
      logic [KEY_W-1:0] key_first;
      logic [KEY_W-1:0] key_second;
      logic last_item;
   } item_type;

   typedef struct packed {
      logic [CFG_W-1:0] exact_limit;
      logic [CFG_W-1:0] sample_count;
   } cfg_type;

   typedef struct packed {
      logic emitting;
      logic [CFG_W-1:0] entry_count;
   } stat_type;

   // multiply by the fnv prime modulo 2^64
   function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
      logic [HASH_W+8:0] lo;
      lo = h * HASH_PRIME_LO;
      return lo[HASH_W-1:0] + {h[HASH_W-41:0], 40'd0};
   endfunction
endpackage
`default_nettype wire

FILE: hdl/hoss_if.sv
// channel interfaces: request items, result items, register writes
`timescale 1ns / 1ps
`default_nettype none
interface hoss_req_if import hoss_pkg::*; ();
   logic valid;
   logic ready;
   logic [VALUE_W-1:0] value_bits;
   logic [KEY_W-1:0] key_first;
   logic [KEY_W-1:0] key_second;
   logic last_item;
   modport source (output valid, value_bits, key_first, key_second, last_item, input ready);
   modport sink (input valid, value_bits, key_first, key_second, last_item, output ready);
endinterface

interface hoss_rsp_if import hoss_pkg::*; ();
   logic valid;
   logic ready;
   logic [VALUE_W-1:0] sample_value;
   logic last_result;
   modport source (output valid, sample_value, last_result, input ready);
   modport sink (input valid, sample_value, last_result, output ready);
endinterface

interface hoss_csr_if import hoss_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/hoss_front.sv
// front end: accepts request items into a two entry queue
`timescale 1ns / 1ps
`default_nettype none
module hoss_front import hoss_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic in_valid,
   output logic in_ready,
   input wire item_type in_item,
   output logic q_valid,
   output item_type q_item,
   input wire logic q_pop
);
   item_type slot_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic push;

   assign in_ready = (fill_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (fill_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      fill_in = fill_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/hoss_back.sv
// back end: hashes and stores entries, then passes or selects values
`timescale 1ns / 1ps
`default_nettype none
module hoss_back import hoss_pkg::*; #(
   parameter int ENTRY_CAPACITY = DEFAULT_ENTRY_CAPACITY
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic q_valid,
   input wire item_type q_item,
   output logic q_pop,
   input wire cfg_type cfg,
   output logic out_valid,
   output logic [VALUE_W-1:0] out_value,
   output logic out_last,
   input wire logic out_ready,
   output stat_type stat
);
   localparam int IW = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
   localparam int CW = $clog2(ENTRY_CAPACITY + 1);
   localparam int HK_W = HASH_W + 2 * KEY_W;
   localparam logic [CW-1:0] CAP = CW'(ENTRY_CAPACITY);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_HASH = 4'd1;
   localparam logic [3:0] S_WRITE = 4'd2;
   localparam logic [3:0] S_PASS_RD = 4'd3;
   localparam logic [3:0] S_PASS_OUT = 4'd4;
   localparam logic [3:0] S_SCAN = 4'd5;
   localparam logic [3:0] S_DRAIN = 4'd6;
   localparam logic [3:0] S_FETCH = 4'd7;
   localparam logic [3:0] S_SEL_OUT = 4'd8;

   logic [VALUE_W-1:0] value_mem [ENTRY_CAPACITY];
   logic [HK_W-1:0] hk_mem [ENTRY_CAPACITY];

   logic [3:0] state_ff, state_in;
   item_type item_ff;
   logic [HASH_W-1:0] h1_ff, hash_now;
   logic [CW-1:0] count_ff, count_in, n_ff, n_in, k_ff, k_in, cnt_new;
   logic [IW-1:0] scan_ff, scan_in, rd_idx_ff, best_idx_ff, best_idx_in;
   logic rd_vld_ff, best_vld_ff, best_vld_in;
   logic [HK_W-1:0] hk_rd_ff, best_hk_ff, best_hk_in;
   logic [ENTRY_CAPACITY-1:0] used_ff, used_in;
   logic [VALUE_W-1:0] vrd_ff;
   logic [IW-1:0] vaddr;
   logic out_vld_ff, out_vld_in, out_last_ff, out_last_in;
   logic [VALUE_W-1:0] out_val_ff;
   logic out_free, emit, store_en, pass_all, last_emit;

   assign out_free = !out_vld_ff || out_ready;
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign hash_now = mul_prime(h1_ff ^ {{(HASH_W-KEY_W){1'b0}}, item_ff.key_second});
   assign store_en = (state_ff == S_WRITE) && (count_ff < CAP);
   assign cnt_new = store_en ? count_ff + 1'b1 : count_ff;
   assign pass_all = (CFG_W'(cnt_new) <= cfg.exact_limit) || (cfg.sample_count == '0)
      || (CFG_W'(cnt_new) <= cfg.sample_count);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in = n_ff;
      k_in = k_ff;
      scan_in = scan_ff;
      used_in = used_ff;
      best_vld_in = best_vld_ff;
      best_hk_in = best_hk_ff;
      best_idx_in = best_idx_ff;
      emit = 1'b0;
      last_emit = 1'b0;
      vaddr = (state_ff == S_FETCH || state_ff == S_SEL_OUT) ? best_idx_ff : k_ff[IW-1:0];
      // running minimum over the scanned entries, earlier index wins a tie
      if (rd_vld_ff && !used_ff[rd_idx_ff] && (!best_vld_ff || hk_rd_ff < best_hk_ff)) begin
         best_vld_in = 1'b1;
         best_hk_in = hk_rd_ff;
         best_idx_in = rd_idx_ff;
      end
      case (state_ff)
         S_IDLE: begin
            if (q_valid) state_in = S_HASH;
         end
         S_HASH: state_in = S_WRITE;
         S_WRITE: begin
            if (!item_ff.last_item) begin
               count_in = cnt_new;
               state_in = S_IDLE;
            end else begin
               n_in = cnt_new;
               count_in = '0;
               k_in = '0;
               scan_in = '0;
               used_in = '0;
               best_vld_in = 1'b0;
               state_in = pass_all ? S_PASS_RD : S_SCAN;
            end
         end
         S_PASS_RD: state_in = S_PASS_OUT;
         S_PASS_OUT: begin
            if (out_free) begin
               emit = 1'b1;
               last_emit = (k_ff + 1'b1 == n_ff);
               k_in = k_ff + 1'b1;
               state_in = last_emit ? S_IDLE : S_PASS_RD;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (CW'(scan_ff) == n_ff - 1'b1) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_FETCH;
         S_FETCH: state_in = S_SEL_OUT;
         S_SEL_OUT: begin
            if (out_free) begin
               emit = 1'b1;
               last_emit = (CFG_W'(k_ff) + 1'b1 == cfg.sample_count);
               used_in[best_idx_ff] = 1'b1;
               k_in = k_ff + 1'b1;
               scan_in = '0;
               best_vld_in = 1'b0;
               state_in = last_emit ? S_IDLE : S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_vld_in = emit ? 1'b1 : (out_ready ? 1'b0 : out_vld_ff);
      out_last_in = emit ? last_emit : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rd_vld_ff <= 1'b0;
         best_vld_ff <= 1'b0;
         used_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_vld_ff <= (state_ff == S_SCAN);
         best_vld_ff <= best_vld_in;
         used_ff <= used_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) item_ff <= q_item;
      h1_ff <= mul_prime(HASH_BASIS ^ {{(HASH_W-KEY_W){1'b0}}, item_ff.key_first});
      n_ff <= n_in;
      k_ff <= k_in;
      scan_ff <= scan_in;
      rd_idx_ff <= scan_ff;
      best_hk_ff <= best_hk_in;
      best_idx_ff <= best_idx_in;
      out_last_ff <= out_last_in;
      if (emit) out_val_ff <= vrd_ff;
   end

   // entry stores
   always_ff @(posedge clock) begin
      if (store_en) begin
         value_mem[count_ff[IW-1:0]] <= item_ff.value_bits;
         hk_mem[count_ff[IW-1:0]] <= {hash_now, item_ff.key_first, item_ff.key_second};
      end
      vrd_ff <= value_mem[vaddr];
      hk_rd_ff <= hk_mem[scan_ff];
   end

   assign out_valid = out_vld_ff;
   assign out_value = out_val_ff;
   assign out_last = out_last_ff;
   assign stat.emitting = (state_ff == S_PASS_RD) || (state_ff == S_PASS_OUT)
      || (state_ff == S_SCAN) || (state_ff == S_DRAIN) || (state_ff == S_FETCH)
      || (state_ff == S_SEL_OUT);
   assign stat.entry_count = CFG_W'(count_ff);
endmodule
`default_nettype wire

FILE: hdl/hash_ordered_sample_select.sv
// top level of the hash ordered sample select block
//
// channel   direction  handshake      payload
// req_ch    in         valid/ready    value_bits, key_first, key_second, last_item
// rsp_ch    out        valid/ready    sample_value, last_result
// csr_ch    in         valid/ready    index, data (ready always high)
//
// each entry goes through the back end states for pop, first hash multiply, then second
// multiply and store write; the two entry queue lets the front accept while that runs
// pass through reads each value from the value store read port, then emits it
// selection, per emitted value: one scan over the n stored entries through the
// key/hash store read port, then a value store read
// reset is synchronous; no clearing pass, stores are only read below the entry count
// rsp_ch stalls hold the back end; the front keeps filling its queue meanwhile
`include "hash_ordered_sample_select_defines.svh"
`timescale 1ns / 1ps
`default_nettype none
module hash_ordered_sample_select import hoss_pkg::*; #(
   parameter int ENTRY_CAPACITY = DEFAULT_ENTRY_CAPACITY
) (
   input wire logic clock,
   input wire logic reset,
   hoss_req_if.sink req_ch,
   hoss_rsp_if.source rsp_ch,
   hoss_csr_if.sink csr_ch
);
   localparam logic [CFG_W-1:0] CAP_LIMIT = CFG_W'(ENTRY_CAPACITY);

   item_type in_item, q_item;
   logic q_valid, q_pop;
   cfg_type cfg_ff;
   stat_type stat;
   logic set_closed, rsp_stall;
   logic [VALUE_W+1:0] rsp_word;

   // configuration registers, always ready
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_EXACT_LIMIT: cfg_ff.exact_limit <= csr_ch.data;
            REG_SAMPLE_COUNT: cfg_ff.sample_count <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // pack the request payload
   assign in_item.value_bits = req_ch.value_bits;
   assign in_item.key_first = req_ch.key_first;
   assign in_item.key_second = req_ch.key_second;
   assign in_item.last_item = req_ch.last_item;

   hoss_front u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_ch.valid),
      .in_ready(req_ch.ready),
      .in_item(in_item),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   hoss_back #(.ENTRY_CAPACITY(ENTRY_CAPACITY)) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .cfg(cfg_ff),
      .out_valid(rsp_ch.valid),
      .out_value(rsp_ch.sample_value),
      .out_last(rsp_ch.last_result),
      .out_ready(rsp_ch.ready),
      .stat(stat)
   );

   // terms for the checks below
   assign set_closed = !stat.emitting || (stat.entry_count == '0);
   assign rsp_stall = rsp_ch.valid && !rsp_ch.ready;
   assign rsp_word = {rsp_ch.valid, rsp_ch.sample_value, rsp_ch.last_result};

   // entry count never passes capacity
   `HOSS_ASSERT_NOW(a_count_cap, clock, reset, stat.entry_count <= CAP_LIMIT, "count over cap")
   // the set is closed while its values go out
   `HOSS_ASSERT_NOW(a_closed_emit, clock, reset, set_closed, "entries stored during emission")
   // a stalled result item holds still
   `HOSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, $stable(rsp_word), "held item changed")
endmodule
`default_nettype wire
